[src/udp_receive_checksum_checker_unit_defines.svh]
// Assertion helpers shared by the checker RTL.
`ifndef UDP_RECEIVE_CHECKSUM_CHECKER_UNIT_DEFINES_SVH
`define UDP_RECEIVE_CHECKSUM_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define URCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define URCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/urcc_pkg.sv]
`timescale 1ns / 1ps
package urcc_pkg;

  localparam logic [15:0] SERVICE_PORT_RESET = 16'd53;
  localparam logic [15:0] UDP_PROTOCOL       = 16'd17;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;
  localparam logic [15:0] CHECKSUM_ABSENT    = 16'h0000;
  localparam logic [15:0] CHECKSUM_ALL_ONES  = 16'hFFFF;
  localparam logic [7:0]  LOWER_A            = 8'h61;
  localparam logic [7:0]  LOWER_Z            = 8'h7A;
  localparam logic [7:0]  CASE_SHIFT         = 8'h20;

  // header byte positions
  localparam logic [2:0] POS_PORT_HI = 3'd2;
  localparam logic [2:0] POS_PORT_LO = 3'd3;
  localparam logic [2:0] POS_LEN_HI  = 3'd4;
  localparam logic [2:0] POS_LEN_LO  = 3'd5;
  localparam logic [2:0] POS_CKS_HI  = 3'd6;
  localparam logic [2:0] POS_CKS_LO  = 3'd7;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] target_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       to_service;
    logic       end_flag;
    logic       length_ok;
    logic       checksum_present;
    logic       checksum_ok;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        to_service;
    logic        end_flag;
    logic        length_ok;
    logic        checksum_present;
    logic [15:0] received_checksum;
    logic [15:0] partial_sum;
    logic [15:0] length_field;
    logic [31:0] source_address;
    logic [31:0] target_address;
  } q_entry_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[src/urcc_front.sv]
`timescale 1ns / 1ps
module urcc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  urcc_pkg::in_item_t in_data,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output urcc_pkg::q_entry_t q_data
);
  import urcc_pkg::*;

  logic [15:0] service_port;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  pending_high, pending_high_next;
  logic        odd_position, odd_position_next;
  logic [15:0] port_field, port_field_next;
  logic [15:0] length_field, length_field_next;
  logic [15:0] received_checksum, received_checksum_next;

  logic        accept;
  logic        in_header;
  logic [7:0]  sum_byte;
  logic [15:0] word;
  logic        to_service;
  logic [7:0]  ob;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign in_header = (byte_count[15:3] == 13'd0);

  always_comb begin
    sum_byte               = in_data.in_byte;
    port_field_next        = port_field;
    length_field_next      = length_field;
    received_checksum_next = received_checksum;
    if (in_header) begin
      unique case (byte_count[2:0])
        POS_PORT_HI: port_field_next[15:8] = in_data.in_byte;
        POS_PORT_LO: port_field_next[7:0]  = in_data.in_byte;
        POS_LEN_HI:  length_field_next[15:8] = in_data.in_byte;
        POS_LEN_LO:  length_field_next[7:0]  = in_data.in_byte;
        POS_CKS_HI: begin
          received_checksum_next[15:8] = in_data.in_byte;
          sum_byte = 8'd0;
        end
        POS_CKS_LO: begin
          received_checksum_next[7:0] = in_data.in_byte;
          sum_byte = 8'd0;
        end
        default: ;
      endcase
    end

    // an odd tail byte on the last transaction is padded with zero
    word = odd_position ? {pending_high, sum_byte} : {sum_byte, 8'd0};
    running_sum_next  = (odd_position || in_data.last_byte) ? oc_add(running_sum, word)
                                                           : running_sum;
    pending_high_next = odd_position ? pending_high : sum_byte;
    odd_position_next = !odd_position;
    byte_count_next   = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;

    to_service = (port_field_next == service_port);
    ob = 8'd0;
    if (!in_header) begin
      ob = in_data.in_byte;
      if (!to_service && in_data.in_byte >= LOWER_A && in_data.in_byte <= LOWER_Z) begin
        ob = in_data.in_byte - CASE_SHIFT;
      end
    end

    q_push = accept && (!in_header || in_data.last_byte);
    q_data.out_byte          = ob;
    q_data.has_byte          = !in_header;
    q_data.to_service        = to_service;
    q_data.end_flag          = in_data.last_byte;
    q_data.length_ok         = in_data.last_byte && (length_field_next == byte_count_next);
    q_data.checksum_present  = in_data.last_byte && (received_checksum_next != CHECKSUM_ABSENT);
    q_data.received_checksum = received_checksum_next;
    q_data.partial_sum       = running_sum_next;
    q_data.length_field      = length_field_next;
    q_data.source_address    = in_data.source_address;
    q_data.target_address    = in_data.target_address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      service_port      <= SERVICE_PORT_RESET;
      byte_count        <= '0;
      running_sum       <= '0;
      pending_high      <= '0;
      odd_position      <= 1'b0;
      port_field        <= '0;
      length_field      <= '0;
      received_checksum <= '0;
    end else begin
      if (cfg_write) begin
        service_port <= cfg_data;
      end
      if (accept) begin
        if (in_data.last_byte) begin
          byte_count        <= '0;
          running_sum       <= '0;
          pending_high      <= '0;
          odd_position      <= 1'b0;
          port_field        <= '0;
          length_field      <= '0;
          received_checksum <= '0;
        end else begin
          byte_count        <= byte_count_next;
          running_sum       <= running_sum_next;
          pending_high      <= pending_high_next;
          odd_position      <= odd_position_next;
          port_field        <= port_field_next;
          length_field      <= length_field_next;
          received_checksum <= received_checksum_next;
        end
      end
    end
  end

  `include "udp_receive_checksum_checker_unit_defines.svh"

  `URCC_ASSERT_NXT(a_front_clear_on_end, accept && in_data.last_byte, byte_count == 16'd0 && !odd_position && running_sum == 16'd0, "state not cleared after end of datagram")
  `URCC_ASSERT_IMP(a_front_push_needs_room, q_push, !q_full, "push into full queue")

endmodule

[src/urcc_queue.sv]
`timescale 1ns / 1ps
module urcc_queue #(
  parameter int Depth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  urcc_pkg::q_entry_t push_data,
  output logic               full,
  output logic               valid,
  input  logic               pop,
  output urcc_pkg::q_entry_t pop_data
);
  import urcc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t            entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == FullCnt);
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  `include "udp_receive_checksum_checker_unit_defines.svh"

  `URCC_ASSERT_IMP(a_queue_pop_nonempty, pop, valid, "pop from empty queue")
  `URCC_ASSERT_IMP(a_queue_count_range, 1'b1, count <= FullCnt, "queue count out of range")

endmodule

[src/urcc_back.sv]
`timescale 1ns / 1ps
module urcc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  urcc_pkg::q_entry_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output urcc_pkg::out_item_t out_data
);
  import urcc_pkg::*;

  logic        s1_valid;
  q_entry_t    s1_entry;
  logic [17:0] s1_sum_a;
  logic [17:0] s1_sum_b;

  logic        out_load;
  logic        s1_load;
  logic [17:0] sum_a;
  logic [17:0] sum_b;
  logic [18:0] raw;
  logic [16:0] fold1;
  logic [15:0] folded;
  logic [15:0] expected;
  logic        match;
  out_item_t   result;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign q_pop    = q_valid && s1_load;

  // partial sum and pseudo-header terms, split in two groups
  assign sum_a = {2'b00, q_data.partial_sum}
               + {2'b00, q_data.source_address[31:16]}
               + {2'b00, q_data.source_address[15:0]}
               + {2'b00, q_data.target_address[31:16]};
  assign sum_b = {2'b00, q_data.target_address[15:0]}
               + {2'b00, q_data.length_field}
               + {2'b00, UDP_PROTOCOL};

  always_comb begin
    raw      = {1'b0, s1_sum_a} + {1'b0, s1_sum_b};
    fold1    = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
    folded   = fold1[15:0] + {15'd0, fold1[16]};
    expected = ~folded;
    match    = (expected == s1_entry.received_checksum) ||
               (expected == CHECKSUM_ABSENT && s1_entry.received_checksum == CHECKSUM_ALL_ONES);
    result.out_byte         = s1_entry.out_byte;
    result.has_byte         = s1_entry.has_byte;
    result.to_service       = s1_entry.to_service;
    result.end_flag         = s1_entry.end_flag;
    result.length_ok        = s1_entry.length_ok;
    result.checksum_present = s1_entry.checksum_present;
    result.checksum_ok      = s1_entry.end_flag && (!s1_entry.checksum_present || match);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= q_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_entry <= q_data;
      s1_sum_a <= sum_a;
      s1_sum_b <= sum_b;
    end
    if (out_load && s1_valid) begin
      out_data <= result;
    end
  end

  `include "udp_receive_checksum_checker_unit_defines.svh"

  `URCC_ASSERT_NXT(a_back_stage_holds, s1_valid && !out_load, s1_valid, "sum stage dropped a transaction")
  `URCC_ASSERT_IMP(a_back_flags_at_end, out_valid && !out_data.end_flag, !out_data.length_ok && !out_data.checksum_present && !out_data.checksum_ok, "verdict flags set before end")

endmodule

[src/udp_receive_checksum_checker_unit.sv]
`timescale 1ns / 1ps
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------
// in       | in_valid / in_stall     | in_data  (urcc_pkg::in_item_t)
// out      | out_valid / out_stall   | out_data (urcc_pkg::out_item_t)
// config   | cfg_write               | cfg_data (service_port)
//
// One byte transaction per cycle while in_stall is low; the running sum adds once per
// 16-bit word. A result passes from the queue through the pseudo-header sum stage,
// then through fold and compare into the output register.
// Header bytes other than a final one produce no result.
// Reset clears the datagram state and loads service_port with 53.
// out_stall holds the output register, then the sum stage, then fills the
// queue; in_stall rises only while the queue is full.
module udp_receive_checksum_checker_unit #(
  parameter int QueueDepth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  urcc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output urcc_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_data
);
  import urcc_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_in;
  q_entry_t q_out;

  urcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  urcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  urcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
